### rtl/core/gsrf_pkg.sv
// ----------------------------------------------------------------------------
// gsrf_pkg
// Shared types and constants of the gear-sampled resemblance feature block.
// ----------------------------------------------------------------------------
package gsrf_pkg;

    localparam int WORD_W  = 64;
    localparam int FEAT_W  = 4;
    localparam int GEAR_AW = 8;
    localparam int GEAR_DEPTH = 256;

    typedef enum logic [1:0] {
        CMD_LOAD_GEAR = 2'd0,
        CMD_LOAD_MULT = 2'd1,
        CMD_LOAD_OFFS = 2'd2,
        CMD_DATA      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_WAIT = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [7:0]            index;
        logic [WORD_W-1:0]     load_value;
        logic [7:0]            data_byte;
        logic                  chunk_end;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]     feature_value;
        logic [FEAT_W-1:0]     feat_id;
        logic                  final_feature;
    } out_item_t;

    // item handed from cell to cell along the chain
    typedef struct packed {
        logic                  valid;
        logic                  sample;
        logic                  last;
        logic                  ld_mult;
        logic                  ld_offs;
        logic [FEAT_W-1:0]     idx;
        logic [WORD_W-1:0]     data;
    } wave_t;

endpackage

### rtl/core/gsrf_front.sv
// ----------------------------------------------------------------------------
// gsrf_front
// Gear table, rolling hash and launch of items into the feature cell chain.
// ----------------------------------------------------------------------------
module gsrf_front #(
    parameter int FEATURE_COUNT = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  gsrf_pkg::in_item_t          item,
    input  logic [gsrf_pkg::WORD_W-1:0] mask,
    output gsrf_pkg::wave_t             wave
);

    logic [gsrf_pkg::WORD_W-1:0] gear_mem [gsrf_pkg::GEAR_DEPTH];
    logic [gsrf_pkg::WORD_W-1:0] gear_q_reg;

    logic                        st_valid_reg;
    gsrf_pkg::cmd_t              st_cmd_reg;
    logic [7:0]                  st_idx_reg;
    logic [gsrf_pkg::WORD_W-1:0] st_value_reg;
    logic                        st_last_reg;

    logic [gsrf_pkg::WORD_W-1:0] hash_reg;
    logic [gsrf_pkg::WORD_W-1:0] hash_next;
    logic [gsrf_pkg::WORD_W-1:0] hash_sum;
    gsrf_pkg::wave_t             wave_reg;
    gsrf_pkg::wave_t             wave_next;
    logic                        sampled;
    logic                        idx_ok;
    logic                        is_data;

    // gear table write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == gsrf_pkg::CMD_LOAD_GEAR)
        begin
            gear_mem[item.index] <= item.load_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gear_q_reg <= gear_mem[item.data_byte];
        end
    end

    // one stage while the gear word is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_cmd_reg   <= item.cmd;
            st_idx_reg   <= item.index;
            st_value_reg <= item.load_value;
            st_last_reg  <= item.chunk_end;
        end
    end

    always_comb
    begin
        is_data   = (st_cmd_reg == gsrf_pkg::CMD_DATA);
        hash_sum  = {hash_reg[gsrf_pkg::WORD_W-2:0], 1'b0} + gear_q_reg;
        sampled   = ((hash_sum & mask) == '0);
        idx_ok    = (st_idx_reg < 8'(FEATURE_COUNT));

        hash_next = hash_reg;
        if (st_valid_reg && is_data)
        begin
            hash_next = st_last_reg ? '0 : hash_sum;
        end

        wave_next         = '0;
        wave_next.sample  = is_data && sampled;
        wave_next.last    = is_data && st_last_reg;
        wave_next.ld_mult = (st_cmd_reg == gsrf_pkg::CMD_LOAD_MULT);
        wave_next.ld_offs = (st_cmd_reg == gsrf_pkg::CMD_LOAD_OFFS);
        wave_next.idx     = st_idx_reg[gsrf_pkg::FEAT_W-1:0];
        wave_next.data    = is_data ? hash_sum : st_value_reg;
        // only items that touch the cells enter the chain
        wave_next.valid   = st_valid_reg &&
                            ((is_data && (sampled || st_last_reg)) ||
                             ((wave_next.ld_mult || wave_next.ld_offs) && idx_ok));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            wave_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            wave_reg <= wave_next;
        end
    end

    assign wave = wave_reg;

endmodule

### rtl/core/gsrf_cell.sv
// ----------------------------------------------------------------------------
// gsrf_cell
// One feature: multiplier, offset and running maximum, passing items onward.
// ----------------------------------------------------------------------------
module gsrf_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gsrf_pkg::wave_t             wave_in,
    output gsrf_pkg::wave_t             wave_out,
    input  logic                        shift_en,
    input  logic [gsrf_pkg::WORD_W-1:0] max_in,
    output logic [gsrf_pkg::WORD_W-1:0] max_out,
    output logic                        done
);

    localparam int HW = gsrf_pkg::WORD_W / 2;

    gsrf_pkg::wave_t             pass_reg;
    logic [gsrf_pkg::WORD_W-1:0] mult_reg;
    logic [gsrf_pkg::WORD_W-1:0] offs_reg;
    logic [gsrf_pkg::WORD_W-1:0] max_reg;
    logic [gsrf_pkg::WORD_W-1:0] max_next;

    logic                        s1_valid_reg;
    logic                        s1_last_reg;
    logic [gsrf_pkg::WORD_W-1:0] p0_reg;
    logic [HW-1:0]               p1_reg;
    logic [HW-1:0]               p2_reg;
    logic [gsrf_pkg::WORD_W-1:0] off1_reg;

    logic                        s2_valid_reg;
    logic                        s2_last_reg;
    logic [gsrf_pkg::WORD_W-1:0] t_reg;

    logic                        mine;
    logic [HW-1:0]               mid_sum;

    assign mine = wave_in.valid && (wave_in.idx == gsrf_pkg::FEAT_W'(CELL_INDEX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            max_reg      <= '0;
        end
        else
        begin
            pass_reg     <= wave_in;
            s1_valid_reg <= wave_in.valid && wave_in.sample;
            s1_last_reg  <= wave_in.valid && wave_in.last;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            max_reg      <= max_next;
        end
    end

    // coefficient loads
    always_ff @(posedge clk)
    begin
        if (mine && wave_in.ld_mult)
        begin
            mult_reg <= wave_in.data;
        end
        if (mine && wave_in.ld_offs)
        begin
            offs_reg <= wave_in.data;
        end
    end

    // low 64 bits of hash * mult from three 32x32 partial products
    always_ff @(posedge clk)
    begin
        p0_reg   <= gsrf_pkg::WORD_W'(wave_in.data[HW-1:0]) *
                    gsrf_pkg::WORD_W'(mult_reg[HW-1:0]);
        p1_reg   <= wave_in.data[gsrf_pkg::WORD_W-1:HW] * mult_reg[HW-1:0];
        p2_reg   <= wave_in.data[HW-1:0] * mult_reg[gsrf_pkg::WORD_W-1:HW];
        off1_reg <= offs_reg;
    end

    assign mid_sum = p1_reg + p2_reg;

    always_ff @(posedge clk)
    begin
        t_reg <= p0_reg + {mid_sum, {HW{1'b0}}} + off1_reg;
    end

    always_comb
    begin
        max_next = max_reg;
        if (shift_en)
        begin
            max_next = max_in;
        end
        else if (s2_valid_reg && (t_reg > max_reg))
        begin
            max_next = t_reg;
        end
    end

    assign wave_out = pass_reg;
    assign max_out  = max_reg;
    assign done     = s2_last_reg;

endmodule

### rtl/core/gear_sampled_resemblance_features_top.sv
// ----------------------------------------------------------------------------
// gear_sampled_resemblance_features_top
// Gear-hash resemblance feature extractor built as a chain of feature cells.
// ----------------------------------------------------------------------------
// loads and chunk bytes are taken one transaction per clock while a chunk
// streams: a byte reads the 256-word gear table, updates the 64-bit rolling
// hash in the next cycle and, when sampled, sends the hash down a row of
// FEATURE_COUNT cells, one cell further each clock; every cell multiplies by
// its own coefficient over two stages and keeps its maximum. multiplier and
// offset loads travel down the same row, so they apply to later bytes only.
// the final byte of a chunk closes the input until its hash has reached and
// settled in the last cell, then the features leave through cell 0 in index
// order, one result transaction per clock that out_ready allows, the row
// shifting towards cell 0 and filling with zero behind; input reopens after
// the last feature. gear, multiplier and offset entries read before being
// written return anything. the user must write the sample mask through
// cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module gear_sampled_resemblance_features_top #(
    parameter int FEATURE_COUNT = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [gsrf_pkg::WORD_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  gsrf_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output gsrf_pkg::out_item_t         out_data
);

    gsrf_pkg::state_t            state_reg;
    gsrf_pkg::state_t            state_next;
    logic [gsrf_pkg::FEAT_W-1:0] count_reg;
    logic [gsrf_pkg::FEAT_W-1:0] count_next;
    logic [gsrf_pkg::WORD_W-1:0] mask_reg;

    logic                        in_accept;
    logic                        out_accept;
    logic                        last_feature;

    gsrf_pkg::wave_t             wave_chain [FEATURE_COUNT+1];
    logic [gsrf_pkg::WORD_W-1:0] max_chain  [FEATURE_COUNT+1];
    logic [FEATURE_COUNT-1:0]    done_vec;

    assign in_accept    = in_valid && in_ready;
    assign out_accept   = out_valid && out_ready;
    assign last_feature = (count_reg == gsrf_pkg::FEAT_W'(FEATURE_COUNT - 1));

    // sample mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mask_reg <= cfg_wr_data;
        end
    end

    // hash front end
    gsrf_front #(
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .item        (in_data),
        .mask        (mask_reg),
        .wave        (wave_chain[0])
    );

    // row of feature cells, zero shifted in behind the last one
    assign max_chain[FEATURE_COUNT] = '0;

    for (genvar g = 0; g < FEATURE_COUNT; g++)
    begin : g_cell
        gsrf_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wave_in  (wave_chain[g]),
            .wave_out (wave_chain[g+1]),
            .shift_en (out_accept),
            .max_in   (max_chain[g+1]),
            .max_out  (max_chain[g]),
            .done     (done_vec[g])
        );
    end

    // control: streaming, draining the row, sending features
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsrf_pkg::ST_RUN;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            gsrf_pkg::ST_RUN:
            begin
                in_ready = 1'b1;
                if (in_valid && in_data.cmd == gsrf_pkg::CMD_DATA && in_data.chunk_end)
                begin
                    state_next = gsrf_pkg::ST_WAIT;
                end
            end
            gsrf_pkg::ST_WAIT:
            begin
                // last cell has folded in the final byte
                if (done_vec[FEATURE_COUNT-1])
                begin
                    state_next = gsrf_pkg::ST_EMIT;
                end
            end
            gsrf_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_feature)
                    begin
                        count_next = '0;
                        state_next = gsrf_pkg::ST_RUN;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = gsrf_pkg::ST_RUN;
                count_next = '0;
            end
        endcase
    end

    assign out_data.feature_value  = max_chain[0];
    assign out_data.feat_id        = count_reg;
    assign out_data.final_feature  = last_feature;

endmodule

### rtl/core/gsrf_checker.sv
// ----------------------------------------------------------------------------
// gsrf_checker
// Port-level checks of the resemblance feature block, bound to the top level.
// ----------------------------------------------------------------------------
module gsrf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input gsrf_pkg::in_item_t          in_data,
    input logic                        out_valid,
    input logic                        out_ready,
    input gsrf_pkg::out_item_t         out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // features follow one another without a gap in valid
    a_out_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.final_feature |=> out_valid)
        else $error("feature burst broken");

    // numbering steps by one within a burst
    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.final_feature
        |=> out_data.feat_id == $past(out_data.feat_id) + 4'd1)
        else $error("feature number out of order");

    // the burst stops after the final feature
    a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.final_feature |=> !out_valid)
        else $error("result after final feature");

    // input closes once a chunk is ended
    a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.cmd == gsrf_pkg::CMD_DATA && in_data.chunk_end
        |=> !in_ready)
        else $error("input still open after chunk end");

endmodule

bind gear_sampled_resemblance_features_top gsrf_checker u_gsrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### dv/gear_sampled_resemblance_features_top_tb.sv
// ----------------------------------------------------------------------------
// gear_sampled_resemblance_features_top_tb
// Self-checking bench for the gear-hash resemblance feature extractor.
// ----------------------------------------------------------------------------
// a queue-fed driver sends loads and chunk bytes, and a clocked monitor feeds
// every accepted transaction into a local copy of the hash, tables and
// feature maxima. each final byte queues twelve predicted features, which are
// compared in order with what the block emits. five sample masks are run,
// from zero to all ones, under different idling patterns, with one long
// receiver hold-off and pauses until everything has drained.
// ----------------------------------------------------------------------------
module gear_sampled_resemblance_features_top_tb;

    localparam int FEATURE_COUNT  = 12;
    localparam int SETTLE_CYCLES  = FEATURE_COUNT + 28;  // pause after everything has drained
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 200000;

    // ------------------------------------------------------------------
    // signals towards the block, all known from time zero
    // ------------------------------------------------------------------
    logic                          clk;
    logic                          rst_n       = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [gsrf_pkg::WORD_W-1:0]   cfg_wr_data = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    gsrf_pkg::in_item_t            in_data     = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    gsrf_pkg::out_item_t           out_data;

    gear_sampled_resemblance_features_top #(
        .FEATURE_COUNT (FEATURE_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    gsrf_pkg::in_item_t          item_backlog[$];       // transactions waiting for the driver
    gsrf_pkg::out_item_t         expected_features[$];  // predicted results, oldest first
    gsrf_pkg::out_item_t         want;

    // shadow of the block, updated on each accepted transaction
    logic [gsrf_pkg::WORD_W-1:0] gear_shadow [gsrf_pkg::GEAR_DEPTH];
    logic [gsrf_pkg::WORD_W-1:0] mult_shadow [FEATURE_COUNT];
    logic [gsrf_pkg::WORD_W-1:0] offs_shadow [FEATURE_COUNT];
    logic [gsrf_pkg::WORD_W-1:0] feat_max    [FEATURE_COUNT];
    logic [gsrf_pkg::WORD_W-1:0] hash_shadow = '0;
    logic [gsrf_pkg::WORD_W-1:0] mask_shadow = '0;

    // gear entries already written, so that chunk bytes never hit an empty one
    bit                          gear_loaded [gsrf_pkg::GEAR_DEPTH];
    gsrf_pkg::cmd_t              load_kinds [3] = '{gsrf_pkg::CMD_LOAD_GEAR,
                                                    gsrf_pkg::CMD_LOAD_MULT,
                                                    gsrf_pkg::CMD_LOAD_OFFS};

    bit                in_took;               // input transaction at the last rising edge
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       rx_hold_reqs   = 0;
    int unsigned       rx_hold_seen   = 0;
    int unsigned       rx_hold_left   = 0;
    int unsigned       items_outstanding = 0;
    int unsigned       items_queued   = 0;
    int unsigned       items_taken    = 0;
    int unsigned       results_seen   = 0;
    int unsigned       chunks_closed  = 0;
    int unsigned       fail_cnt       = 0;
    int unsigned       cycle_cnt      = 0;

    // ------------------------------------------------------------------
    // clock, period 20
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: hash update, sampling and the emit on a final byte
    // ------------------------------------------------------------------
    function automatic void absorb_transaction(input gsrf_pkg::in_item_t it);
        logic [gsrf_pkg::WORD_W-1:0] t;
        gsrf_pkg::out_item_t         f;
        case (it.cmd)
            gsrf_pkg::CMD_LOAD_GEAR: gear_shadow[it.index] = it.load_value;
            gsrf_pkg::CMD_LOAD_MULT:
                if (it.index < FEATURE_COUNT) mult_shadow[it.index] = it.load_value;
            gsrf_pkg::CMD_LOAD_OFFS:
                if (it.index < FEATURE_COUNT) offs_shadow[it.index] = it.load_value;
            gsrf_pkg::CMD_DATA:
            begin
                hash_shadow = (hash_shadow << 1) + gear_shadow[it.data_byte];
                // sampled position: every feature keeps its running maximum
                if ((hash_shadow & mask_shadow) == '0)
                begin
                    for (int j = 0; j < FEATURE_COUNT; j++)
                    begin
                        t = hash_shadow * mult_shadow[j] + offs_shadow[j];
                        if (t > feat_max[j])
                            feat_max[j] = t;
                    end
                end
                // the final byte is hashed first, then the features leave in order
                if (it.chunk_end)
                begin
                    for (int j = 0; j < FEATURE_COUNT; j++)
                    begin
                        f.feature_value = feat_max[j];
                        f.feat_id       = gsrf_pkg::FEAT_W'(j);
                        f.final_feature = (j == FEATURE_COUNT - 1);
                        expected_features = {expected_features, f};
                    end
                    foreach (feat_max[j])
                        feat_max[j] = '0;
                    hash_shadow = '0;
                    chunks_closed++;
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [gsrf_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_loaded_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (!gear_loaded[b]);
        return b;
    endfunction

    task automatic push_item(input gsrf_pkg::in_item_t it);
        item_backlog = {item_backlog, it};
        items_outstanding++;
        items_queued++;
    endtask

    // load transaction; the data byte carries noise
    task automatic queue_load(input gsrf_pkg::cmd_t kind, input logic [7:0] idx,
                              input logic [gsrf_pkg::WORD_W-1:0] value, input logic last);
        gsrf_pkg::in_item_t it;
        it.cmd        = kind;
        it.index      = idx;
        it.load_value = value;
        it.data_byte  = 8'($urandom_range(255));
        it.chunk_end  = last;
        if (kind == gsrf_pkg::CMD_LOAD_GEAR)
            gear_loaded[idx] = 1'b1;
        push_item(it);
    endtask

    // chunk byte; index and load value carry noise
    task automatic queue_byte(input logic [7:0] b, input logic last);
        gsrf_pkg::in_item_t it;
        it.cmd        = gsrf_pkg::CMD_DATA;
        it.index      = 8'($urandom_range(255));
        it.load_value = rand_word();
        it.data_byte  = b;
        it.chunk_end  = last;
        push_item(it);
    endtask

    task automatic queue_random_load();
        gsrf_pkg::cmd_t kind;
        logic [7:0]     idx;
        kind = load_kinds[$urandom_range(2)];
        // feature loads mostly in range, now and then past the last feature
        if (kind == gsrf_pkg::CMD_LOAD_GEAR || $urandom_range(3) == 0)
            idx = 8'($urandom_range(255));
        else
            idx = 8'($urandom_range(FEATURE_COUNT - 1));
        queue_load(kind, idx, rand_word(), 1'($urandom_range(1)));
    endtask

    // well-formed chunks with loads mixed in between the bytes
    task automatic queue_random_items(input int unsigned n);
        int unsigned target;
        int          len;
        target = items_queued + n;
        while (items_queued < target)
        begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(99) < 15)
                    queue_random_load();
                queue_byte(pick_loaded_byte(), k == len - 1);
            end
        end
    endtask

    // wait until every transaction is in and every feature has come back
    task automatic wait_drained(input bit settle);
        while (items_outstanding != 0 || expected_features.size() != 0)
            @(negedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_mask(input logic [gsrf_pkg::WORD_W-1:0] m);
        cfg_wr_data <= m;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // driver: a new transaction is presented at the falling edge once the
    // previous one has been taken, or after an idle cycle
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= item_backlog.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, or stalled throughout a hold-off
    always @(negedge clk)
        out_ready <= rst_n && rx_hold_left == 0 && $urandom_range(99) >= recv_stall_pct;

    // long receiver hold-off, counted here, started by a request from the sequence
    always @(posedge clk)
    begin
        if (rx_hold_seen != rx_hold_reqs)
        begin
            rx_hold_seen <= rx_hold_reqs;
            rx_hold_left <= RX_HOLD_CYCLES;
        end
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // ------------------------------------------------------------------
    // monitor: register writes, accepted input and result transactions
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_took = 1'b0;
        if (rst_n)
        begin
            if (cfg_wr_en)
                mask_shadow = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                in_took = 1'b1;
                absorb_transaction(in_data);
                items_outstanding--;
                items_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_features.size() == 0)
                begin
                    $error("unexpected feature result: number %0d value %h",
                           out_data.feat_id, out_data.feature_value);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_features.pop_front();
                    results_seen++;
                    if (out_data.feature_value !== want.feature_value)
                    begin
                        $error("feature_value: expected %h, got %h",
                               want.feature_value, out_data.feature_value);
                        fail_cnt++;
                    end
                    if (out_data.feat_id !== want.feat_id)
                    begin
                        $error("feat_id: expected %0d, got %0d",
                               want.feat_id, out_data.feat_id);
                        fail_cnt++;
                    end
                    if (out_data.final_feature !== want.final_feature)
                    begin
                        $error("final_feature: expected %0b, got %0b",
                               want.final_feature, out_data.final_feature);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles", cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        foreach (feat_max[j])
            feat_max[j] = '0;

        // reset held, then released on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // phase 0: sample every position, no idling
        load_mask('0);

        // tables first, so no byte reads an empty entry; the extremes go in here
        queue_load(gsrf_pkg::CMD_LOAD_GEAR, 8'h00, '0, 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_GEAR, 8'hff, '1, 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_GEAR, 8'h55, rand_word(), 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_GEAR, 8'haa, rand_word(), 1'b1);
        queue_load(gsrf_pkg::CMD_LOAD_GEAR, 8'h01, rand_word(), 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_GEAR, 8'h80, rand_word(), 1'b0);
        for (int j = 0; j < FEATURE_COUNT; j++)
        begin
            queue_load(gsrf_pkg::CMD_LOAD_MULT, 8'(j), (j == 0) ? '0 : (j == 1) ? 64'd1 :
                       (j == 2) ? '1 : rand_word(), 1'(j % 2));
            queue_load(gsrf_pkg::CMD_LOAD_OFFS, 8'(j),
                       (j == 0) ? '1 : (j == 1) ? '0 : rand_word(), 1'((j + 1) % 2));
        end

        // feature loads past the last feature are dropped, even where they alias
        queue_load(gsrf_pkg::CMD_LOAD_MULT, 8'(FEATURE_COUNT + 4), rand_word(), 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_OFFS, 8'(FEATURE_COUNT), rand_word(), 1'b1);
        queue_load(gsrf_pkg::CMD_LOAD_MULT, 8'hff, rand_word(), 1'b0);
        // zero hash sampled, then an all-ones hash hashed on the final byte
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hff, 1'b1);
        // loads inside a chunk act on the very next byte; chunk_end on a load is ignored
        queue_byte(8'h55, 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_GEAR, 8'h55, rand_word(), 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_MULT, 8'd3, '1, 1'b0);
        queue_load(gsrf_pkg::CMD_LOAD_OFFS, 8'(FEATURE_COUNT - 1), '1, 1'b1);
        queue_byte(8'haa, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b1);

        queue_random_items(8);
        wait_drained(1'b1);

        // phase 1: sample only a zero hash, sender mostly idle
        send_idle_pct  = 75;
        recv_stall_pct = 0;
        load_mask('1);
        queue_random_items(6);
        // sender pauses until every feature is back
        wait_drained(1'b0);
        queue_random_items(6);
        wait_drained(1'b1);

        // phase 2: two adjacent mask bits, receiver stalling plus a long hold-off
        // while the sender keeps offering, so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        load_mask(64'h3 << $urandom_range(62));
        rx_hold_reqs++;
        queue_random_items(16);
        wait_drained(1'b1);

        // phase 3: two random mask bits, both sides idling
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        load_mask((64'h1 << $urandom_range(63)) | (64'h1 << $urandom_range(63)));
        queue_random_items(12);
        wait_drained(1'b1);

        // phase 4: top bit only, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_mask(64'h1 << 63);
        queue_random_items(12);
        wait_drained(1'b1);

        if (expected_features.size() != 0)
        begin
            $error("%0d predicted features never arrived", expected_features.size());
            fail_cnt++;
        end

        $display("covered %0d input transactions, %0d chunks and %0d feature results",
                 items_taken, chunks_closed, results_seen);
        $display("five sample masks from zero to all ones, four idling patterns, one hold-off");
        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
